>>> src/planar_odometry_integrator_core_macros.svh
// Assertion macros for the planar odometry integrator.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define PDO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdo: same-cycle check failed");

// consequence must hold in the cycle after the antecedent
`define PDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdo: next-cycle check failed");

`endif

>>> src/pdo_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the odometry integrator.
package pdo_pkg;

    localparam int TRIG_BITS_DEF   = 16;
    localparam int CORDIC_ITERS    = 31;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int MUL_W           = 33;

    typedef logic [4:0] t_iter;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input t_iter idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> src/pdo_mul.sv
// Shared registered signed multiplier used by the odometry sequencer.
module pdo_mul (
    input  logic                                 i_clk,
    input  logic signed [pdo_pkg::MUL_W-1:0]     i_a,
    input  logic signed [pdo_pkg::MUL_W-1:0]     i_b,
    output logic signed [2*pdo_pkg::MUL_W-1:0]   o_p
);

    logic signed [2*pdo_pkg::MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> src/pdo_cordic.sv
// Iterative CORDIC: one rotation step per cycle, quadrant folding, rounding and saturation.
module pdo_cordic #(
    parameter int TRIG_BITS = pdo_pkg::TRIG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_angle,
    output logic                        o_done,
    output logic signed [TRIG_BITS-1:0] o_cos,
    output logic signed [TRIG_BITS-1:0] o_sin
);

    localparam int XW = 33;
    localparam int ZW = 34;
    localparam int S  = 31 - TRIG_BITS;
    localparam logic signed [XW:0] HALF   = (XW+1)'(64'd1 << (S - 1));
    localparam logic signed [XW:0] LIM_HI = (XW+1)'((64'd1 << (TRIG_BITS - 1)) - 64'd1);
    localparam logic signed [XW:0] LIM_LO = -LIM_HI - (XW+1)'(1);
    localparam pdo_pkg::t_iter LAST_ITER = 5'(pdo_pkg::CORDIC_ITERS - 1);

    logic                  r_busy;
    logic                  r_fin;
    pdo_pkg::t_iter        r_iter;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [ZW-1:0]  r_z;
    logic [1:0]            r_q;

    logic [31:0]           w_qsum;
    logic [1:0]            w_q;
    logic [31:0]           w_ru;
    logic signed [XW-1:0]  w_dx;
    logic signed [XW-1:0]  w_dy;
    logic signed [ZW-1:0]  w_atan;
    logic signed [TRIG_BITS-1:0] w_c;
    logic signed [TRIG_BITS-1:0] w_s;

    function automatic logic signed [TRIG_BITS-1:0] trig_round(input logic signed [XW-1:0] v);
        logic signed [XW:0] sum;
        logic signed [XW:0] sh;
        logic signed [XW:0] sat;
        sum = {v[XW-1], v} + HALF;
        sh  = sum >>> S;
        if (sh > LIM_HI) begin
            sat = LIM_HI;
        end else if (sh < LIM_LO) begin
            sat = LIM_LO;
        end else begin
            sat = sh;
        end
        return TRIG_BITS'(sat);
    endfunction

    // nearest quadrant, residual in [-1/8, 1/8) turn
    assign w_qsum = i_angle + 32'h2000_0000;
    assign w_q    = w_qsum[31:30];
    assign w_ru   = i_angle - {w_q, 30'd0};

    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = {2'b00, pdo_pkg::atan_turn(r_iter)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_iter <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 5'd1;
                if (r_iter == LAST_ITER) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= XW'(pdo_pkg::CORDIC_GAIN_Q30);
            r_y <= '0;
            r_z <= {{(ZW-32){w_ru[31]}}, w_ru};
            r_q <= w_q;
        end else if (r_busy) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign w_c = trig_round(r_x);
    assign w_s = trig_round(r_y);

    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = w_c;
                o_sin = w_s;
            end
            2'd1: begin
                o_cos = -w_s;
                o_sin = w_c;
            end
            2'd2: begin
                o_cos = -w_c;
                o_sin = -w_s;
            end
            default: begin
                o_cos = w_s;
                o_sin = -w_c;
            end
        endcase
    end

    assign o_done = r_fin;

endmodule

>>> src/planar_odometry_integrator_core.sv
// Planar dead-reckoning odometry integrator: stream top level and step sequencer.
// Flow: each input transaction runs 31 CORDIC iterations, then 11 multiply/accumulate
// steps on the shared multiplier, then a publish step.
// Throughput: one input transaction at a time, limited by the CORDIC iteration loop and
// the single multiplier; a held result stalls only the final publish step.
// Reset (synchronous, active low) clears pose, previous timestamp and handshake state.
`include "planar_odometry_integrator_core_macros.svh"

module planar_odometry_integrator_core #(
    parameter int TRIG_BITS = pdo_pkg::TRIG_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] time_us, [47:32] vel_x_mm_s, [63:48] vel_y_mm_s, [95:64] yaw_rate
    input  logic [95:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [63:0] pos_x_nm, [127:64] pos_y_nm, [159:128] heading_angle
    output logic [159:0] o_m_axis_tdata
);

    localparam int MW   = pdo_pkg::MUL_W;
    localparam int RW   = TRIG_BITS + 17;
    localparam int AW   = TRIG_BITS + 16;
    localparam int PW   = TRIG_BITS + 48;
    localparam int SH   = TRIG_BITS - 1;
    localparam logic [PW-1:0] RND_HALF = PW'(64'd1 << (SH - 1));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TRIG = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_PUB  = 2'd3;

    localparam logic [3:0] STEP_VX_C   = 4'd0;
    localparam logic [3:0] STEP_VY_S   = 4'd1;
    localparam logic [3:0] STEP_VX_S   = 4'd2;
    localparam logic [3:0] STEP_VY_C   = 4'd3;
    localparam logic [3:0] STEP_YAW    = 4'd4;
    localparam logic [3:0] STEP_X_LO   = 4'd5;
    localparam logic [3:0] STEP_X_HI   = 4'd6;
    localparam logic [3:0] STEP_Y_LO   = 4'd7;
    localparam logic [3:0] STEP_Y_HI   = 4'd8;
    localparam logic [3:0] STEP_Y_SUM  = 4'd9;
    localparam logic [3:0] STEP_LAST   = 4'd10;

    logic [1:0]   r_state;
    logic [1:0]   n_state;
    logic [3:0]   r_step;
    logic [3:0]   n_step;

    logic [31:0]  r_prev;
    logic [31:0]  r_dt;
    logic signed [15:0] r_vx;
    logic signed [15:0] r_vy;
    logic [31:0]  r_yaw;
    logic signed [TRIG_BITS-1:0] r_cos;
    logic signed [TRIG_BITS-1:0] r_sin;
    logic signed [RW-1:0] r_rx;
    logic signed [RW-1:0] r_ry;
    logic [AW-1:0] r_magx;
    logic [AW-1:0] r_magy;
    logic         r_negx;
    logic         r_negy;
    logic [PW-1:0] r_px;
    logic [PW-1:0] r_py;
    logic [63:0]  r_accx;
    logic [63:0]  r_accy;
    logic [31:0]  r_head;
    logic         r_ovalid;
    logic [159:0] r_odata;

    logic         w_accept;
    logic         w_pub;
    logic         w_trig_done;
    logic signed [TRIG_BITS-1:0] w_cos;
    logic signed [TRIG_BITS-1:0] w_sin;
    logic signed [MW-1:0]   w_mul_a;
    logic signed [MW-1:0]   w_mul_b;
    logic signed [2*MW-1:0] w_prod;
    logic [63:0]  w_p64;
    logic [PW-1:0] w_plo;
    logic [PW-1:0] w_phi;
    logic [63:0]  w_magx_ext;
    logic [63:0]  w_magy_ext;
    logic [63:0]  w_resx;
    logic [63:0]  w_resy;
    logic signed [MW-1:0] w_vx_ext;
    logic signed [MW-1:0] w_vy_ext;
    logic signed [MW-1:0] w_cos_ext;
    logic signed [MW-1:0] w_sin_ext;
    logic signed [MW-1:0] w_dt_ext;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pub           = (r_state == ST_PUB) && (!r_ovalid || i_m_axis_tready);

    pdo_cordic #(
        .TRIG_BITS (TRIG_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_angle (r_head),
        .o_done  (w_trig_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // operand select: step k issues its product, step k+1 consumes it
    assign w_vx_ext   = {{(MW-16){r_vx[15]}}, r_vx};
    assign w_vy_ext   = {{(MW-16){r_vy[15]}}, r_vy};
    assign w_cos_ext  = {{(MW-TRIG_BITS){r_cos[TRIG_BITS-1]}}, r_cos};
    assign w_sin_ext  = {{(MW-TRIG_BITS){r_sin[TRIG_BITS-1]}}, r_sin};
    assign w_dt_ext   = {1'b0, r_dt};
    assign w_magx_ext = 64'(r_magx);
    assign w_magy_ext = 64'(r_magy);

    always_comb begin
        case (r_step)
            STEP_VX_C: begin
                w_mul_a = w_vx_ext;
                w_mul_b = w_cos_ext;
            end
            STEP_VY_S: begin
                w_mul_a = w_vy_ext;
                w_mul_b = w_sin_ext;
            end
            STEP_VX_S: begin
                w_mul_a = w_vx_ext;
                w_mul_b = w_sin_ext;
            end
            STEP_VY_C: begin
                w_mul_a = w_vy_ext;
                w_mul_b = w_cos_ext;
            end
            STEP_YAW: begin
                w_mul_a = {r_yaw[31], r_yaw};
                w_mul_b = w_dt_ext;
            end
            STEP_X_LO: begin
                w_mul_a = {1'b0, w_magx_ext[31:0]};
                w_mul_b = w_dt_ext;
            end
            STEP_X_HI: begin
                w_mul_a = {1'b0, w_magx_ext[63:32]};
                w_mul_b = w_dt_ext;
            end
            STEP_Y_LO: begin
                w_mul_a = {1'b0, w_magy_ext[31:0]};
                w_mul_b = w_dt_ext;
            end
            STEP_Y_HI: begin
                w_mul_a = {1'b0, w_magy_ext[63:32]};
                w_mul_b = w_dt_ext;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    pdo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_p64  = w_prod[63:0];
    assign w_plo  = PW'(w_p64);
    assign w_phi  = PW'(w_p64) << 32;
    assign w_resx = 64'(r_px[PW-1:SH]);
    assign w_resy = 64'(r_py[PW-1:SH]);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG: begin
                if (w_trig_done) begin
                    n_state = ST_MUL;
                    n_step  = STEP_VX_C;
                end
            end
            ST_MUL: begin
                n_step = r_step + 4'd1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_PUB;
                end
            end
            ST_PUB: begin
                if (w_pub) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_VX_C;
            r_ovalid <= 1'b0;
            r_prev   <= '0;
            r_accx   <= '0;
            r_accy   <= '0;
            r_head   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_pub) begin
                r_ovalid <= 1'b1;
            end
            if (w_accept) begin
                r_prev <= i_s_axis_tdata[31:0];
            end
            if (r_state == ST_MUL) begin
                case (r_step)
                    STEP_X_LO: begin
                        r_head <= r_head + w_p64[31:0];
                    end
                    // x step is complete once the high partial product is folded in
                    STEP_Y_HI: begin
                        r_accx <= r_accx + (w_resx ^ {64{r_negx}}) + 64'(r_negx);
                    end
                    STEP_LAST: begin
                        r_accy <= r_accy + (w_resy ^ {64{r_negy}}) + 64'(r_negy);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt  <= i_s_axis_tdata[31:0] - r_prev;
            r_vx  <= i_s_axis_tdata[47:32];
            r_vy  <= i_s_axis_tdata[63:48];
            r_yaw <= i_s_axis_tdata[95:64];
        end
        if ((r_state == ST_TRIG) && w_trig_done) begin
            r_cos <= w_cos;
            r_sin <= w_sin;
        end
        if (r_state == ST_MUL) begin
            case (r_step)
                STEP_VY_S: begin
                    r_rx <= RW'(w_prod);
                end
                STEP_VX_S: begin
                    r_rx <= r_rx - RW'(w_prod);
                end
                STEP_VY_C: begin
                    r_ry   <= RW'(w_prod);
                    r_negx <= r_rx[RW-1];
                    r_magx <= r_rx[RW-1] ? AW'(-r_rx) : AW'(r_rx);
                end
                STEP_YAW: begin
                    r_ry <= r_ry + RW'(w_prod);
                end
                STEP_X_LO: begin
                    r_negy <= r_ry[RW-1];
                    r_magy <= r_ry[RW-1] ? AW'(-r_ry) : AW'(r_ry);
                end
                STEP_X_HI: begin
                    r_px <= w_plo + RND_HALF;
                end
                STEP_Y_LO: begin
                    r_px <= r_px + w_phi;
                end
                STEP_Y_HI: begin
                    r_py <= w_plo + RND_HALF;
                end
                STEP_Y_SUM: begin
                    r_py <= r_py + w_phi;
                end
                default: begin
                end
            endcase
        end
        if (w_pub) begin
            r_odata <= {r_head, r_accy, r_accx};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    `PDO_ASSERT_SAME(a_trig_done_in_trig, i_clk, i_rst_n, w_trig_done, r_state == ST_TRIG)
    `PDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_axis_tready)
    `PDO_ASSERT_SAME(a_step_in_range, i_clk, i_rst_n, r_state == ST_MUL, r_step <= STEP_LAST)
    `PDO_ASSERT_NEXT(a_pub_holds, i_clk, i_rst_n, (r_state == ST_PUB) && r_ovalid && !i_m_axis_tready, (r_state == ST_PUB) && r_ovalid)

endmodule
